>>> rtl/bit_field_extractor_top_macros.svh
// assertion macros shared by the checker
`ifndef BIT_FIELD_EXTRACTOR_TOP_MACROS_SVH
`define BIT_FIELD_EXTRACTOR_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define BFE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bfe_pkg.sv
`default_nettype none

package bfe_pkg;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_START,
        ST_FMT,
        ST_OUT
    } state_t;

    // request kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_ZERO  = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;
    localparam logic [1:0] ERR_WIDE  = 2'd3;

    // type selects
    localparam logic [2:0] SEL_U8  = 3'd0;
    localparam logic [2:0] SEL_U16 = 3'd1;
    localparam logic [2:0] SEL_U32 = 3'd2;
    localparam logic [2:0] SEL_U64 = 3'd3;
    localparam logic [2:0] SEL_S32 = 3'd4;

    // register indexes
    localparam logic REG_BIT_ORDER   = 1'b0;
    localparam logic REG_DATA_LENGTH = 1'b1;

    // formatting request handed to the format pipeline
    typedef struct packed
    {
        logic [2:0] rsh;
        logic [6:0] len;
        logic       little;
        logic       sext;
    } fmt_req_t;

    function automatic logic [6:0] type_limit(input logic [2:0] sel);
        logic [6:0] lim;
        begin
            case (sel)
                SEL_U8:  lim = 7'd8;
                SEL_U16: lim = 7'd16;
                SEL_U32: lim = 7'd32;
                SEL_U64: lim = 7'd64;
                SEL_S32: lim = 7'd32;
                default: lim = 7'd0;
            endcase
            return lim;
        end
    endfunction

    // ones in the low len bits
    function automatic logic [63:0] len_mask(input logic [6:0] len);
        logic [63:0] m;
        begin
            if (len[6])
            begin
                m = '1;
            end
            else
            begin
                m = (64'd1 << len[5:0]) - 64'd1;
            end
            return m;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/bit_field_extractor_top.sv
// bit field extractor
// input stream (s_*): one request per beat, s_tuser is the kind, 0 load and 1 read.
// a load writes byte_value to buffer byte byte_index and gives no result. a read
// returns one result on the output stream (m_*): the field of bit_length bits at
// bit_offset (bit 0 is the msb of byte 0), big or little order per bit_order,
// limited by type_sel, and an error code.
// a read needs n = ceil(((bit_offset mod 8) + bit_length) / 8) buffer bytes, up to
// nine, fetched one per cycle from the byte ram's single read port. the window then
// passes a wait state, a start state and the format pipeline into the output
// register, and the next request is taken once the result is there. a read that fails
// its checks skips the ram and goes straight to the output register, then the next
// request is taken.
// the apb port holds bit_order (0x0) and data_length (0x4); write them only
// while the block is idle.
// reset clears the control state and the registers; the buffer is not cleared
// and a byte must be loaded before any read covers it.
// a stalled receiver holds the result in the output register; a further read
// finishes its work and then waits until that register frees up.
`default_nettype none

module bit_field_extractor_top
    import bfe_pkg::*;
#(
    parameter int BUF_BYTES = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] byte_index, [15:8] byte_value, [26:16] bit_offset,
    // [33:27] bit_length, [36:34] type_sel, [39:37] zero
    input  wire logic [39:0] s_tdata,
    // [0] kind
    input  wire logic        s_tuser,
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [63:0] field_value, [65:64] error_code, [71:66] zero
    output logic      [71:0] m_tdata,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
    localparam logic [12:0] BUF_LIM = 13'(BUF_BYTES);

    // request fields
    logic [7:0]  byte_index;
    logic [7:0]  byte_value;
    logic [10:0] bit_offset;
    logic [6:0]  bit_length;
    logic [2:0]  type_sel;

    assign byte_index = s_tdata[7:0];
    assign byte_value = s_tdata[15:8];
    assign bit_offset = s_tdata[26:16];
    assign bit_length = s_tdata[33:27];
    assign type_sel   = s_tdata[36:34];

    state_t state_reg, state_next;

    // configuration registers
    logic       bit_order_reg;
    logic [8:0] data_length_reg;

    // per-read context
    logic [1:0] err_reg, err_next;
    logic [3:0] nb_reg, nb_next;
    logic [7:0] base_reg;
    logic [3:0] iss_cnt_reg;
    fmt_req_t   req_reg, req_next;

    // byte window and ram read tracking
    logic        rd_pend_reg;
    logic [71:0] acc_reg;

    // output register
    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg;

    // control decode
    logic        in_acc;
    logic        mem_we;
    logic        mem_re;
    logic        fmt_start;
    logic        out_load;
    logic [7:0]  mem_rdata;
    logic [AW-1:0] mem_raddr;
    logic        fmt_done;
    logic [63:0] fmt_value;

    // request checks
    logic [12:0] avail;
    logic [15:0] end_bit;
    logic [6:0]  tot;
    logic [7:0]  tot_up;

    assign pready = 1'b1;

    // register port: word index from paddr[2]
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_order_reg   <= 1'b0;
            data_length_reg <= 9'd0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_DATA_LENGTH)
            begin
                data_length_reg <= pwdata[8:0];
            end
            else
            begin
                bit_order_reg <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_DATA_LENGTH) ? {23'd0, data_length_reg}
                                                  : {31'd0, bit_order_reg};

    // error checks on the incoming read, in priority order
    always_comb
    begin
        avail   = ({4'd0, data_length_reg} > BUF_LIM) ? BUF_LIM : {4'd0, data_length_reg};
        end_bit = {5'd0, bit_offset} + {9'd0, bit_length};
        if (type_sel == SEL_S32 && bit_length > 7'd32)
        begin
            err_next = ERR_WIDE;
        end
        else if (bit_length == 7'd0)
        begin
            err_next = ERR_ZERO;
        end
        else if (end_bit > {avail, 3'b000})
        begin
            err_next = ERR_RANGE;
        end
        else if (bit_length > type_limit(type_sel))
        begin
            err_next = ERR_WIDE;
        end
        else
        begin
            err_next = ERR_OK;
        end
    end

    // bytes spanned and trailing bits to drop in the last byte
    always_comb
    begin
        tot             = {4'd0, bit_offset[2:0]} + bit_length;
        tot_up          = {1'b0, tot} + 8'd7;
        nb_next         = tot_up[6:3];
        req_next.rsh    = 3'(3'd0 - tot[2:0]);
        req_next.len    = bit_length;
        req_next.little = bit_order_reg;
        req_next.sext   = (type_sel == SEL_S32);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tuser == KIND_READ)
                begin
                    state_next = (err_next == ERR_OK) ? ST_READ : ST_OUT;
                end
            end
            ST_READ:
            begin
                if (iss_cnt_reg == nb_reg - 4'd1)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_FMT;
            end
            ST_FMT:
            begin
                if (fmt_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        mem_re    = (state_reg == ST_READ);
        fmt_start = (state_reg == ST_START);
        out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    end

    assign in_acc = s_tvalid && s_tready;
    assign mem_we = in_acc && (s_tuser == KIND_LOAD) && ({5'd0, byte_index} < BUF_LIM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            iss_cnt_reg  <= 4'd0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= mem_re;
            if (in_acc)
            begin
                iss_cnt_reg <= 4'd0;
            end
            else if (mem_re)
            begin
                iss_cnt_reg <= iss_cnt_reg + 4'd1;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // read context and payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc && s_tuser == KIND_READ)
        begin
            err_reg  <= err_next;
            nb_reg   <= nb_next;
            base_reg <= bit_offset[10:3];
            req_reg  <= req_next;
        end
        // bytes shift in msb first, the last one lands in the low byte
        if (rd_pend_reg)
        begin
            acc_reg <= {acc_reg[63:0], mem_rdata};
        end
        if (out_load)
        begin
            m_tdata_reg <= {6'd0, err_reg, (err_reg == ERR_OK) ? fmt_value : 64'd0};
        end
    end

    assign mem_raddr = AW'({1'b0, base_reg} + {5'd0, iss_cnt_reg});

    bfe_byte_ram
    #(
        .DEPTH (BUF_BYTES),
        .AW    (AW)
    )
    u_ram
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(byte_index)),
        .wdata (byte_value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bfe_fmt u_fmt
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (fmt_start),
        .window (acc_reg),
        .req    (req_reg),
        .done   (fmt_done),
        .value  (fmt_value)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> rtl/bfe_byte_ram.sv
`default_nettype none

module bfe_byte_ram
    import bfe_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/bfe_fmt.sv
`default_nettype none

module bfe_fmt
    import bfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [71:0] window,
    input  wire fmt_req_t    req,
    output logic             done,
    output logic      [63:0] value
);

    logic        v1_reg, v2_reg, v3_reg;
    logic [63:0] s1_reg, s1_next;
    logic [63:0] s2_reg, s2_next;
    logic [63:0] s3_reg, s3_next;
    fmt_req_t    r1_reg, r2_reg;
    logic [71:0] shifted;
    logic [63:0] rev;
    logic [6:0]  rev_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1: drop trailing bits of the last byte, keep len bits
    always_comb
    begin
        shifted = window >> req.rsh;
        s1_next = shifted[63:0] & len_mask(req.len);
    end

    // stage 2: little order reverses the field within len bits
    always_comb
    begin
        for (int i = 0; i < 64; i++)
        begin
            rev[i] = s1_reg[63 - i];
        end
        rev_sh  = 7'd64 - r1_reg.len;
        s2_next = r1_reg.little ? (rev >> rev_sh) : s1_reg;
    end

    // stage 3: sign extension for the signed type
    always_comb
    begin
        s3_next = s2_reg;
        if (r2_reg.sext && s2_reg[r2_reg.len[5:0] - 6'd1])
        begin
            s3_next = s2_reg | ~len_mask(r2_reg.len);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s1_reg <= s1_next;
            r1_reg <= req;
        end
        if (v1_reg)
        begin
            s2_reg <= s2_next;
            r2_reg <= r1_reg;
        end
        if (v2_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign done  = v3_reg;
    assign value = s3_reg;

endmodule

`default_nettype wire

>>> rtl/bfe_checker.sv
`default_nettype none
`include "bit_field_extractor_top_macros.svh"

module bfe_checker
    import bfe_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata
);

    // a result waiting on the receiver holds
    `BFE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "stalled result changed")

    // a failed read carries a zero field
    `BFE_ASSERT_NOW(a_err_zero, m_tvalid && m_tdata[65:64] != ERR_OK,
        m_tdata[63:0] == 64'd0, "error result with nonzero field")

    // an accepted read blocks the input until its result is out
    `BFE_ASSERT_NEXT(a_read_busy, s_tvalid && s_tready && s_tuser == KIND_READ,
        !s_tready, "input ready during a read")

    // a load produces no result
    `BFE_ASSERT_NEXT(a_load_quiet, s_tvalid && s_tready && s_tuser == KIND_LOAD && !m_tvalid,
        !m_tvalid, "load produced a result")

endmodule

bind bit_field_extractor_top bfe_checker u_bfe_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
